@@ src/rwts_pkg.sv @@
package rwts_pkg;

   localparam int SAMPLE_W = 24;
   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd7;
   localparam int CHANGE_W = 16;
   localparam int TOTAL_W = 16;
   localparam int PERCENT = 100;
   localparam int CHG_POS_LIMIT = 32767;
   localparam int CHG_NEG_LIMIT = 32768;

   typedef struct packed {
      logic longer;
      logic full;
      logic first;
   } item_flags_type;

   typedef struct packed {
      logic                       gain_valid;
      logic [SAMPLE_W-1:0]        gain_mean_centi;
      logic                       change_valid;
      logic signed [CHANGE_W-1:0] change_percent;
      logic                       deviation_valid;
      logic [SAMPLE_W-1:0]        deviation_centi;
      logic                       switch_flag;
      logic [TOTAL_W-1:0]         switch_total;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_MULT,
      ST_SUBT,
      ST_ROOT,
      ST_DIVG,
      ST_DIVC,
      ST_DIVD,
      ST_FINISH
   } back_state_type;

endpackage

@@ src/rolling_window_trend_stats.sv @@
// Rolling window trend statistics. Each item is one signed sample in hundredths; each gives
// one result with the mean positive gain, percent change and population standard deviation
// over a window of n = csr_wr_data (clamped to 1..MAX_WINDOW) samples. Items are handled
// one at a time by a sequencer behind a two-entry queue: n+1 ring reads, a square root
// that resolves one bit per cycle and three divisions on one shared one-bit-per-cycle
// divider. Results wait in a two-entry queue. Write the window length only while the
// block is idle.
module rolling_window_trend_stats
   import rwts_pkg::*;
#(
   parameter int MAX_WINDOW = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CFG_W-1:0]           csr_wr_data,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [SAMPLE_W-1:0]        req_sample_centi,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic                       rsp_gain_valid,
   output logic [SAMPLE_W-1:0]        rsp_gain_mean_centi,
   output logic                       rsp_change_valid,
   output logic signed [CHANGE_W-1:0] rsp_change_percent,
   output logic                       rsp_deviation_valid,
   output logic [SAMPLE_W-1:0]        rsp_deviation_centi,
   output logic                       rsp_switch_flag,
   output logic [TOTAL_W-1:0]         rsp_switch_total
);

   localparam int N_W = $clog2(MAX_WINDOW + 1);
   localparam int FLAG_W = $bits(item_flags_type);
   localparam int CMD_W = SAMPLE_W + N_W + FLAG_W;
   localparam int RSP_W = $bits(result_type);

   logic           accept, cmd_full, cmd_empty, cmd_pop;
   logic           rsp_push, rsp_full;
   logic [N_W-1:0] n_win;
   item_flags_type flags;
   logic [CMD_W-1:0] cmd_in, cmd_out;
   logic [RSP_W-1:0] rsp_out;
   result_type     rsp_in, rsp_item;

   assign accept   = req_push && !cmd_full;
   assign req_full = cmd_full;
   assign cmd_in   = {n_win, flags, req_sample_centi};
   assign rsp_item = result_type'(rsp_out);

   rwts_front #(.MAX_WINDOW(MAX_WINDOW), .N_W(N_W)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .n_win       (n_win),
      .flags       (flags)
   );

   rwts_queue #(.W(CMD_W), .DEPTH(2)) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   rwts_back #(.MAX_WINDOW(MAX_WINDOW), .N_W(N_W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_x     (cmd_out[SAMPLE_W-1:0]),
      .cmd_n     (cmd_out[CMD_W-1:SAMPLE_W+FLAG_W]),
      .cmd_flags (item_flags_type'(cmd_out[SAMPLE_W+FLAG_W-1:SAMPLE_W])),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full),
      .rsp_data  (rsp_in)
   );

   rwts_queue #(.W(RSP_W), .DEPTH(2)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty)
   );

   assign rsp_gain_valid      = rsp_item.gain_valid;
   assign rsp_gain_mean_centi = rsp_item.gain_mean_centi;
   assign rsp_change_valid    = rsp_item.change_valid;
   assign rsp_change_percent  = rsp_item.change_percent;
   assign rsp_deviation_valid = rsp_item.deviation_valid;
   assign rsp_deviation_centi = rsp_item.deviation_centi;
   assign rsp_switch_flag     = rsp_item.switch_flag;
   assign rsp_switch_total    = rsp_item.switch_total;

`ifndef ASSERT_OFF
   a_switch_needs_change: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_switch_flag) |-> (rsp_change_valid && rsp_switch_total != '0))
      else $error("switch flag without valid change");

   a_change_needs_deviation: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_change_valid) |-> rsp_deviation_valid)
      else $error("change valid before deviation valid");

   a_invalid_gain_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_gain_valid) |-> (rsp_gain_mean_centi == '0 &&
         rsp_change_percent == '0))
      else $error("invalid statistics not cleared");
`endif

endmodule

@@ src/rwts_queue.sv @@
module rwts_queue
   import rwts_pkg::*;
#(
   parameter int W = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     entry_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule

@@ src/rwts_front.sv @@
module rwts_front
   import rwts_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int N_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [CFG_W-1:0]    csr_wr_data,
   input  logic                accept,
   output logic [N_W-1:0]      n_win,
   output item_flags_type      flags
);

   localparam int SEEN_W = $clog2(MAX_WINDOW + 3);
   localparam int SEEN_LIMIT = MAX_WINDOW + 2;

   logic [CFG_W-1:0]  cfg_ff;
   logic [SEEN_W-1:0] seen_ff, seen_in;

   always_comb begin
      if (cfg_ff == '0) begin
         n_win = N_W'(1);
      end else if (32'(cfg_ff) > 32'(MAX_WINDOW)) begin
         n_win = N_W'(MAX_WINDOW);
      end else begin
         n_win = N_W'(cfg_ff);
      end
      flags.longer = 32'(seen_ff) > 32'(n_win);
      flags.full   = 32'(seen_ff) >= 32'(n_win);
      flags.first  = 32'(seen_ff) == (32'(n_win) + 32'd1);
      seen_in = seen_ff;
      if (accept && (32'(seen_ff) < 32'(SEEN_LIMIT))) begin
         seen_in = seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= CFG_RESET;
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

endmodule

@@ src/rwts_divider.sv @@
module rwts_divider
   import rwts_pkg::*;
#(
   parameter int NUM_W = 34,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output logic             done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      quo_in  = {quo_ff[NUM_W-2:0], 1'b0};
      rem_in  = shifted[DEN_W-1:0];
      if (shifted >= {1'b0, den_ff}) begin
         rem_in    = DEN_W'(shifted - {1'b0, den_ff});
         quo_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= num;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quot = quo_ff;
   assign done = done_ff;

endmodule

@@ src/rwts_isqrt.sv @@
module rwts_isqrt
   import rwts_pkg::*;
#(
   parameter int V_W = 62
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [V_W-1:0]     value,
   output logic [V_W/2-1:0]   root,
   output logic               done
);

   localparam int R_W = V_W / 2;
   localparam int CNT_W = $clog2(R_W + 1);

   logic [V_W-1:0]   val_ff;
   logic [R_W-1:0]   root_ff, root_in;
   logic [R_W:0]     rem_ff, rem_in;
   logic [R_W+2:0]   rem_sh, trial;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;

   always_comb begin
      rem_sh  = {rem_ff, val_ff[V_W-1:V_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      root_in = {root_ff[R_W-2:0], 1'b0};
      rem_in  = rem_sh[R_W:0];
      if (rem_sh >= trial) begin
         rem_in     = (R_W+1)'(rem_sh - trial);
         root_in[0] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(R_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[V_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

@@ src/rwts_back.sv @@
module rwts_back
   import rwts_pkg::*;
#(
   parameter int MAX_WINDOW = 64,
   parameter int N_W = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   input  logic [SAMPLE_W-1:0] cmd_x,
   input  logic [N_W-1:0]      cmd_n,
   input  item_flags_type      cmd_flags,
   output logic                rsp_push,
   input  logic                rsp_full,
   output result_type          rsp_data
);

   localparam int RING_D = MAX_WINDOW + 1;
   localparam int ADDR_W = $clog2(RING_D);
   localparam int S1_W = SAMPLE_W + N_W + 1;
   localparam int MAG_W = SAMPLE_W + N_W;
   localparam int GS_W = SAMPLE_W + N_W + 1;
   localparam int SQ_W = 2 * SAMPLE_W;
   localparam int S2_W = SQ_W + N_W;
   localparam int A_W = S2_W + N_W;
   localparam int B_W = 2 * MAG_W;
   localparam int V_W = ((A_W + 3) / 2) * 2;
   localparam int R_W = V_W / 2;
   localparam int CH_W = SAMPLE_W + 10;
   localparam int G_W = GS_W + 2;
   localparam int DQ_A = (G_W > CH_W) ? G_W : CH_W;
   localparam int DQ_W = (DQ_A > R_W) ? DQ_A : R_W;
   localparam int DEN_W = (SAMPLE_W + 1 > N_W + 2) ? SAMPLE_W + 1 : N_W + 2;

   back_state_type state_ff, state_in;

   logic [SAMPLE_W-1:0] ring [RING_D];
   logic [ADDR_W-1:0]   wp_ff, wp_next, rd_addr;
   logic [N_W-1:0]      k_ff, rd_age_ff, n_ff;
   logic                rd_en, rd_v_ff, sq_v_ff;
   logic signed [SAMPLE_W-1:0] rd_q_ff, prev_ff, base_ff, x_ff;
   item_flags_type      flags_ff;

   logic [GS_W-1:0]        gs_ff;
   logic signed [S1_W-1:0] s1_ff;
   logic [S2_W-1:0]        s2_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic signed [SQ_W-1:0] sq_full;
   logic signed [SAMPLE_W:0] step;
   logic [MAG_W-1:0]       mag;
   logic [A_W-1:0]         a_ff;
   logic [B_W-1:0]         b_ff;
   logic [V_W-1:0]         v_val;

   logic signed [SAMPLE_W-1:0] base_eff;
   logic signed [SAMPLE_W:0]   cdiff;
   logic [SAMPLE_W:0]          adiff;
   logic [SAMPLE_W-1:0]        abase;
   logic [CH_W-1:0]            anum, cnum;
   logic                       chg_neg;
   logic [16:0]                chg_mag;
   logic signed [CHANGE_W-1:0] chg_val, chg_ff;

   logic [SAMPLE_W-1:0] gain_ff, dev_ff;
   logic [DQ_W:0]       dev_sum;
   logic                prev_neg_ff, sw;
   logic [TOTAL_W-1:0]  total_ff, total_next;

   logic             sqrt_start, sqrt_done, div_start, div_done;
   logic [R_W-1:0]   root;
   logic [DQ_W-1:0]  div_num, quot;
   logic [DEN_W-1:0] div_den;

   rwts_isqrt #(.V_W(V_W)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (v_val),
      .root  (root),
      .done  (sqrt_done)
   );

   rwts_divider #(.NUM_W(DQ_W), .DEN_W(DEN_W)) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      wp_next = (wp_ff == ADDR_W'(RING_D - 1)) ? '0 : wp_ff + 1'b1;
      if (wp_ff >= ADDR_W'(k_ff)) begin
         rd_addr = wp_ff - ADDR_W'(k_ff);
      end else begin
         rd_addr = ADDR_W'(({1'b0, wp_ff} + (ADDR_W+1)'(RING_D)) - (ADDR_W+1)'(k_ff));
      end
      step    = $signed({prev_ff[SAMPLE_W-1], prev_ff}) - $signed({rd_q_ff[SAMPLE_W-1], rd_q_ff});
      sq_full = rd_q_ff * rd_q_ff;
      mag     = s1_ff[S1_W-1] ? MAG_W'(-s1_ff) : MAG_W'(s1_ff);
      v_val   = V_W'(a_ff - A_W'(b_ff)) << 2;

      base_eff = (base_ff == '0) ? SAMPLE_W'(PERCENT) : base_ff;
      cdiff    = $signed({x_ff[SAMPLE_W-1], x_ff}) - $signed({base_eff[SAMPLE_W-1], base_eff});
      adiff    = cdiff[SAMPLE_W] ? (SAMPLE_W+1)'(-cdiff) : (SAMPLE_W+1)'(cdiff);
      abase    = base_eff[SAMPLE_W-1] ? SAMPLE_W'(-base_eff) : SAMPLE_W'(base_eff);
      anum     = CH_W'(adiff) * CH_W'(PERCENT);
      cnum     = (anum << 1) + CH_W'(abase);
      chg_neg  = cdiff[SAMPLE_W] != base_eff[SAMPLE_W-1];

      chg_mag = (quot > DQ_W'(CHG_NEG_LIMIT)) ? 17'(CHG_NEG_LIMIT) : quot[16:0];
      if (chg_neg && (quot != '0)) begin
         chg_val = CHANGE_W'(-chg_mag);
      end else if (quot > DQ_W'(CHG_POS_LIMIT)) begin
         chg_val = CHANGE_W'(CHG_POS_LIMIT);
      end else begin
         chg_val = quot[CHANGE_W-1:0];
      end
      dev_sum = {1'b0, quot} + (DQ_W+1)'(1);

      sw = flags_ff.longer && !flags_ff.first && (chg_ff[CHANGE_W-1] != prev_neg_ff);
      total_next = (sw && (total_ff != '1)) ? total_ff + 1'b1 : total_ff;

      rsp_data.gain_valid      = flags_ff.longer;
      rsp_data.gain_mean_centi = flags_ff.longer ? gain_ff : '0;
      rsp_data.change_valid    = flags_ff.longer;
      rsp_data.change_percent  = flags_ff.longer ? chg_ff : '0;
      rsp_data.deviation_valid = flags_ff.full;
      rsp_data.deviation_centi = flags_ff.full ? dev_ff : '0;
      rsp_data.switch_flag     = sw;
      rsp_data.switch_total    = total_next;
   end

   always_comb begin
      state_in   = state_ff;
      cmd_pop    = 1'b0;
      rd_en      = 1'b0;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      rsp_push   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_READ;
         ST_READ: begin
            rd_en = 1'b1;
            if (k_ff == n_ff) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_MULT;
         ST_MULT:   state_in = ST_SUBT;
         ST_SUBT: begin
            sqrt_start = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               div_start = 1'b1;
               div_num   = DQ_W'({gs_ff, 1'b0}) + DQ_W'(n_ff);
               div_den   = DEN_W'({n_ff, 1'b0});
               state_in  = ST_DIVG;
            end
         end
         ST_DIVG: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = DQ_W'(cnum);
               div_den   = DEN_W'({abase, 1'b0});
               state_in  = ST_DIVC;
            end
         end
         ST_DIVC: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = DQ_W'(root);
               div_den   = DEN_W'(n_ff);
               state_in  = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         wp_ff       <= '0;
         k_ff        <= '0;
         rd_v_ff     <= 1'b0;
         sq_v_ff     <= 1'b0;
         prev_neg_ff <= 1'b0;
         total_ff    <= '0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= rd_en;
         sq_v_ff  <= rd_v_ff && (rd_age_ff < n_ff);
         if (state_ff == ST_WRITE) begin
            wp_ff <= wp_next;
            k_ff  <= '0;
         end else if (rd_en) begin
            k_ff <= k_ff + 1'b1;
         end
         if (rsp_push) begin
            total_ff <= total_next;
            if (flags_ff.longer) begin
               prev_neg_ff <= chg_ff[CHANGE_W-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         ring[wp_next] <= x_ff;
      end
      if (rd_en) begin
         rd_q_ff   <= ring[rd_addr];
         rd_age_ff <= k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         x_ff     <= cmd_x;
         n_ff     <= cmd_n;
         flags_ff <= cmd_flags;
      end
      if (state_ff == ST_WRITE) begin
         gs_ff <= '0;
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         if (rd_v_ff) begin
            if ((rd_age_ff != '0) && !step[SAMPLE_W] && (step != '0)) begin
               gs_ff <= gs_ff + GS_W'(step[SAMPLE_W-1:0]);
            end
            if (rd_age_ff < n_ff) begin
               s1_ff <= s1_ff + S1_W'(rd_q_ff);
            end
            if (rd_age_ff == n_ff) begin
               base_ff <= rd_q_ff;
            end
            prev_ff <= rd_q_ff;
            sq_ff   <= SQ_W'(sq_full);
         end
         if (sq_v_ff) begin
            s2_ff <= s2_ff + S2_W'(sq_ff);
         end
      end
      if (state_ff == ST_MULT) begin
         a_ff <= A_W'(n_ff) * A_W'(s2_ff);
         b_ff <= B_W'(mag) * B_W'(mag);
      end
      if (div_done) begin
         unique case (state_ff)
            ST_DIVG: gain_ff <= quot[SAMPLE_W-1:0];
            ST_DIVC: chg_ff  <= chg_val;
            ST_DIVD: dev_ff  <= dev_sum[SAMPLE_W:1];
            default: ;
         endcase
      end
   end

endmodule

@@ verif/rolling_window_trend_stats_tb.sv @@
module rolling_window_trend_stats_tb;
   import rwts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW = 64;
   localparam int RING_DEPTH = MAX_WINDOW + 1;
   localparam int SEEN_LIMIT = MAX_WINDOW + 2;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 400;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_wr_en = 1'b0;
   logic [CFG_W-1:0]           csr_wr_data = '0;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [SAMPLE_W-1:0]        req_sample_centi = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_gain_valid;
   logic [SAMPLE_W-1:0]        rsp_gain_mean_centi;
   logic                       rsp_change_valid;
   logic signed [CHANGE_W-1:0] rsp_change_percent;
   logic                       rsp_deviation_valid;
   logic [SAMPLE_W-1:0]        rsp_deviation_centi;
   logic                       rsp_switch_flag;
   logic [TOTAL_W-1:0]         rsp_switch_total;

   rolling_window_trend_stats #(
      .MAX_WINDOW(MAX_WINDOW)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_push(req_push),
      .req_full(req_full),
      .req_sample_centi(req_sample_centi),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_gain_valid(rsp_gain_valid),
      .rsp_gain_mean_centi(rsp_gain_mean_centi),
      .rsp_change_valid(rsp_change_valid),
      .rsp_change_percent(rsp_change_percent),
      .rsp_deviation_valid(rsp_deviation_valid),
      .rsp_deviation_centi(rsp_deviation_centi),
      .rsp_switch_flag(rsp_switch_flag),
      .rsp_switch_total(rsp_switch_total)
   );

   // trend statistics state
   longint          sample_ring [RING_DEPTH];
   int              write_pos = 0;
   int              samples_seen = 0;
   bit              prev_change_neg = 1'b0;
   int unsigned     flip_tally = 0;
   logic [CFG_W-1:0] window_reg = CFG_RESET;

   result_type      pending_stats [$];
   int              error_count = 0;
   int              items_sent = 0;
   int              results_seen = 0;
   int              switches_seen = 0;
   int              zero_bases = 0;
   int              cycle_count = 0;
   bit              no_idle = 1'b0;
   int              pop_stall = 0;
   longint          walk_value = 0;

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   function automatic longint sample_at(int age);
      return sample_ring[(write_pos + RING_DEPTH - (age % RING_DEPTH)) % RING_DEPTH];
   endfunction

   function automatic logic [SAMPLE_W-1:0] deviation_of(int n);
      longint            s1;
      longint unsigned   s2, mag, lo, hi, mid, t;
      logic [127:0]      d, t2;
      s1 = 0;
      s2 = 0;
      for (int k = 0; k < n; k++) begin
         s1 += sample_at(k);
         s2 += longint'(sample_at(k) * sample_at(k));
      end
      mag = (s1 < 0) ? longint'(-s1) : s1;
      d = (128'(n) * 128'(s2) - 128'(mag) * 128'(mag)) << 2;
      lo = 0;
      hi = 64'd1 << 24;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = (2 * mid - 1) * longint'(n);
         t2 = 128'(t) * 128'(t);
         if (t2 <= d)
            lo = mid;
         else
            hi = mid - 1;
      end
      return lo[SAMPLE_W-1:0];
   endfunction

   function automatic result_type predict_trend_stats(logic [SAMPLE_W-1:0] raw);
      result_type      r;
      longint          x, cur, base, num, d;
      longint unsigned gain_sum, anum, abase, q;
      longint          change;
      bit              longer, full, neg, sw;
      int              n;
      r = '0;
      x = longint'($signed(raw));
      n = window_reg;
      if (n < 1)
         n = 1;
      if (n > MAX_WINDOW)
         n = MAX_WINDOW;
      write_pos = (write_pos + 1) % RING_DEPTH;
      sample_ring[write_pos] = x;
      longer = samples_seen > n;
      full = samples_seen >= n;
      sw = 1'b0;
      change = 0;
      if (longer) begin
         gain_sum = 0;
         for (int k = 0; k < n; k++) begin
            d = sample_at(k) - sample_at(k + 1);
            if (d > 0)
               gain_sum += d;
         end
         r.gain_mean_centi = SAMPLE_W'((2 * gain_sum + n) / (2 * longint'(n)));
         cur = x;
         base = sample_at(n);
         if (base == 0) begin
            base = PERCENT;
            zero_bases++;
         end
         num = (cur - base) * PERCENT;
         anum = (num < 0) ? -num : num;
         abase = (base < 0) ? -base : base;
         q = (2 * anum + abase) / (2 * abase);
         if (q > CHG_NEG_LIMIT)
            q = CHG_NEG_LIMIT;
         neg = (num < 0) != (base < 0);
         if (neg)
            change = -longint'(q);
         else
            change = (q > CHG_POS_LIMIT) ? CHG_POS_LIMIT : longint'(q);
         neg = change < 0;
         if (samples_seen != n + 1 && neg != prev_change_neg) begin
            sw = 1'b1;
            if (flip_tally < 65535)
               flip_tally++;
         end
         prev_change_neg = neg;
      end
      if (full)
         r.deviation_centi = deviation_of(n);
      if (samples_seen < SEEN_LIMIT)
         samples_seen++;
      r.gain_valid = longer;
      r.change_valid = longer;
      r.change_percent = change[CHANGE_W-1:0];
      r.deviation_valid = full;
      r.switch_flag = sw;
      r.switch_total = flip_tally[TOTAL_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_stats.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            want = pending_stats.pop_front();
            if (rsp_gain_valid !== want.gain_valid)
               report_mismatch("gain_valid", rsp_gain_valid, want.gain_valid);
            if (rsp_gain_mean_centi !== want.gain_mean_centi)
               report_mismatch("gain_mean_centi", rsp_gain_mean_centi, want.gain_mean_centi);
            if (rsp_change_valid !== want.change_valid)
               report_mismatch("change_valid", rsp_change_valid, want.change_valid);
            if (rsp_change_percent !== want.change_percent)
               report_mismatch("change_percent", rsp_change_percent, want.change_percent);
            if (rsp_deviation_valid !== want.deviation_valid)
               report_mismatch("deviation_valid", rsp_deviation_valid, want.deviation_valid);
            if (rsp_deviation_centi !== want.deviation_centi)
               report_mismatch("deviation_centi", rsp_deviation_centi, want.deviation_centi);
            if (rsp_switch_flag !== want.switch_flag)
               report_mismatch("switch_flag", rsp_switch_flag, want.switch_flag);
            if (rsp_switch_total !== want.switch_total)
               report_mismatch("switch_total", rsp_switch_total, want.switch_total);
            if (want.switch_flag)
               switches_seen++;
         end
         results_seen++;
      end
   end

   // result side stalls in bursts
   always @(negedge clock) begin
      if (pop_stall > 0 && !no_idle) begin
         rsp_pop <= 1'b0;
         pop_stall <= pop_stall - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!no_idle && $urandom_range(0, 9) == 0)
            pop_stall <= $urandom_range(1, 11);
         else
            pop_stall <= 0;
      end
   end

   task automatic send_sample(logic [SAMPLE_W-1:0] value);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_push <= 1'b1;
      req_sample_centi <= value;
      do
         @(posedge clock);
      while (req_full);
      pending_stats.push_back(predict_trend_stats(value));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_stats.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_window(logic [CFG_W-1:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      window_reg = value;
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         walk_value += longint'($urandom_range(0, 4000)) - 2000;
         if (walk_value > 8388607)
            walk_value = 8388607;
         if (walk_value < -8388608)
            walk_value = -8388608;
         return SAMPLE_W'(walk_value);
      end else if (pick < 7) begin
         return SAMPLE_W'(longint'($urandom_range(0, 1000)) - 500);
      end else if (pick == 7) begin
         return '0;
      end
      return SAMPLE_W'($urandom());
   endfunction

   task automatic test_directed_extremes();
      logic [SAMPLE_W-1:0] vals [25];
      vals = '{24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h7fffff,
               24'h800000, 24'h7fffff, 24'h800000, 24'h000064, 24'hffff9c,
               24'h000001, 24'hffffff, 24'h000000, 24'h000005, 24'h00000a,
               24'h000003, 24'hfffffb, 24'h7fffff, 24'h000000, 24'h800000,
               24'h000001, 24'h000001, 24'h000001, 24'hffffff, 24'h000002};
      write_window(7'd3);
      foreach (vals[i])
         send_sample(vals[i]);
   endtask

   task automatic test_window_extremes();
      logic [CFG_W-1:0] lens [5];
      lens = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd65};
      foreach (lens[i]) begin
         write_window(lens[i]);
         repeat ((i % 2 == 1) ? 40 : 15)
            send_sample(random_sample());
      end
   endtask

   task automatic test_random_windows();
      for (int seg = 0; seg < 16; seg++) begin
         if ($urandom_range(0, 4) == 0)
            write_window(7'($urandom_range(0, 127)));
         else
            write_window(7'($urandom_range(1, 12)));
         if (seg == 8) begin
            wait_drained();
         end
         repeat ($urandom_range(12, 30))
            send_sample(random_sample());
      end
   endtask

   task automatic test_no_idle();
      write_window(7'd5);
      no_idle = 1'b1;
      repeat (50)
         send_sample(random_sample());
   endtask

   initial begin
      int waited;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_extremes();
      test_window_extremes();
      test_random_windows();
      test_no_idle();
      req_push <= 1'b0;
      waited = 0;
      while (pending_stats.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      if (pending_stats.size() != 0) begin
         report_mismatch("missing results", results_seen, items_sent);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d samples, %0d results, %0d sign switches, %0d zero bases",
               items_sent, results_seen, switches_seen, zero_bases);
      $display("windows 0..127 written incl. clamp extremes, %0d mismatches", error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
src/rwts_pkg.sv
src/rwts_queue.sv
src/rwts_front.sv
src/rwts_divider.sv
src/rwts_isqrt.sv
src/rwts_back.sv
src/rolling_window_trend_stats.sv
verif/rolling_window_trend_stats_tb.sv
